// ===== hw/rtl/series_return_statistics_core_macros.svh =====
// Assertion macros shared by the checker of series_return_statistics_core.
`ifndef SERIES_RETURN_STATISTICS_CORE_MACROS_SVH
`define SERIES_RETURN_STATISTICS_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("series_return_statistics_core check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("series_return_statistics_core check failed");

`endif

// ===== hw/rtl/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// Types, constants and helpers of the series return statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

    localparam int COUNT_BITS = 20;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [31:0] RET_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] Q24_ONE    = 32'h0100_0000;
    // Largest ratio whose return still fits: RET_MAX + 1.0 in Q8.24.
    localparam logic [55:0] RATIO_SAT  = 56'h0000_0000_80FF_FFFF;

    // Iteration counts of the shared unit.
    localparam logic [6:0] STEPS_RATIO = 7'd56;
    localparam logic [6:0] STEPS_MEAN  = 7'd33;
    localparam logic [6:0] STEPS_MUL   = 7'd33;
    localparam logic [6:0] STEPS_VAR   = 7'd64;
    localparam logic [6:0] STEPS_SQRT  = 7'd44;

    // Operations of the shared unit.
    localparam logic [1:0] U_DIV  = 2'd0;
    localparam logic [1:0] U_SQRT = 2'd1;
    localparam logic [1:0] U_MUL  = 2'd2;

    // Result kinds.
    localparam logic [3:0] K_START_NAV   = 4'd0;
    localparam logic [3:0] K_START_TOTAL = 4'd1;
    localparam logic [3:0] K_END_NAV     = 4'd2;
    localparam logic [3:0] K_END_TOTAL   = 4'd3;
    localparam logic [3:0] K_MAX_RET     = 4'd4;
    localparam logic [3:0] K_MIN_RET     = 4'd5;
    localparam logic [3:0] K_MIN_NAV     = 4'd6;
    localparam logic [3:0] K_MAX_NAV     = 4'd7;
    localparam logic [3:0] K_MIN_TOTAL   = 4'd8;
    localparam logic [3:0] K_MAX_TOTAL   = 4'd9;
    localparam logic [3:0] K_STD_DEV     = 4'd10;
    localparam logic [3:0] K_COUNT       = 4'd11;

    typedef struct packed {
        logic [21:0] day_number;
        logic [31:0] nav_value;
        logic [47:0] total_value;
        logic        final_day;
    } t_in_word;

    typedef struct packed {
        logic [3:0]         stat_kind;
        logic signed [63:0] stat_value;
        logic [21:0]        stat_day;
        logic               last_stat;
    } t_out_word;

    typedef struct packed {
        logic        start;
        logic [1:0]  mode;
        logic [6:0]  steps;
        logic [87:0] x;
        logic [32:0] d;
    } t_unit_req;

    typedef struct packed {
        logic        done;
        logic [63:0] q;
        logic [65:0] acc;
    } t_unit_rsp;

    function automatic logic [32:0] mag33(input logic [32:0] v);
        return v[32] ? (33'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/series_return_statistics_core.sv =====
// ----------------------------------------------------------------------------
// series_return_statistics_core
// Running return statistics over a series of daily NAV and total samples.
// ----------------------------------------------------------------------------
// Each input word is one day. The first word of a series is the baseline;
// every later word yields a Q8.24 return that feeds min/max tracking and a
// running mean and M2. The word marked final_day produces twelve output words
// in kind order, the last one flagged with last_stat. All arithmetic that
// needs more than an add goes through one shared unit that retires one bit
// per cycle. A baseline word needs no unit work; a later word runs 56 divide
// steps for the ratio (none if the previous NAV is zero), 33 for the mean
// update and 33 multiply steps for M2. A final word with more than one
// return adds the variance divide (64 steps) and square root (44 steps),
// then sends the output words as the receiver takes them. The input
// stall stays high while a word is in work; configuration writes are accepted
// at any time but should only be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module series_return_statistics_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  srs_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output srs_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    import srs_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_RATIO  = 4'd2;
    localparam logic [3:0] S_UPD    = 4'd3;
    localparam logic [3:0] S_MEAN   = 4'd4;
    localparam logic [3:0] S_MSTART = 4'd5;
    localparam logic [3:0] S_MUL    = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_VAR    = 4'd8;
    localparam logic [3:0] S_SQRT   = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    logic [3:0]  r_state, n_state;
    t_in_word    r_item, n_item;
    logic [31:0] r_begin_nav;

    // Series state.
    logic               r_seen, n_seen;
    logic [31:0]        r_start_nav, n_start_nav;
    logic [47:0]        r_start_total, n_start_total;
    logic [31:0]        r_prev, n_prev;
    logic [31:0]        r_nav_min, n_nav_min, r_nav_max, n_nav_max;
    logic [21:0]        r_nav_min_day, n_nav_min_day, r_nav_max_day, n_nav_max_day;
    logic [47:0]        r_tot_min, n_tot_min, r_tot_max, n_tot_max;
    logic [21:0]        r_tot_min_day, n_tot_min_day, r_tot_max_day, n_tot_max_day;
    logic signed [31:0] r_ret_min, n_ret_min, r_ret_max, n_ret_max;
    logic [21:0]        r_ret_min_day, n_ret_min_day, r_ret_max_day, n_ret_max_day;
    logic signed [32:0] r_mean, n_mean;
    logic [63:0]        r_m2, n_m2;
    logic [COUNT_BITS-1:0] r_count, n_count;

    // Per-word working registers.
    logic signed [31:0] r_ret, n_ret;
    logic signed [32:0] r_delta, n_delta;
    logic [43:0]        r_sd, n_sd;
    logic [3:0]         r_k, n_k;
    t_out_word          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    t_unit_req unit_req;
    t_unit_rsp unit_rsp;

    srs_iter_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .o_rsp   (unit_rsp)
    );

    logic                  in_accept;
    logic [COUNT_BITS-1:0] count_inc;
    logic [55:0]           ratio;
    logic signed [31:0]    ret_from_ratio;
    logic signed [32:0]    delta_now;
    logic [32:0]           q_mean;
    logic signed [32:0]    mean_new;
    logic [32:0]           b_mag;
    logic [39:0]           prod;
    logic [64:0]           m2_sum;
    logic                  short_series;
    logic                  out_free;
    t_out_word             sel_word;

    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign count_inc  = (r_count != COUNT_MAX) ? r_count + 1'b1 : r_count;

    // A ratio beyond the Q8.24 range clips; otherwise the return fits 32 bits.
    assign ratio          = unit_rsp.q[55:0];
    assign ret_from_ratio = (ratio > RATIO_SAT) ? RET_MAX : (ratio[31:0] - Q24_ONE);

    assign delta_now = {r_ret[31], r_ret} - r_mean;
    assign q_mean    = unit_rsp.q[32:0];
    assign mean_new  = r_mean + (r_delta[32] ? (33'd0 - q_mean) : q_mean);
    assign b_mag     = mag33({r_ret[31], r_ret} - r_mean);
    assign prod      = unit_rsp.acc[63:24];
    assign m2_sum    = {1'b0, r_m2} + {25'd0, prod};

    assign short_series = (r_count == '0);
    assign out_free     = !r_out_valid || !i_out_stall;

    // Result word for the current kind index.
    always_comb begin
        sel_word.stat_kind  = r_k;
        sel_word.stat_value = 64'sd0;
        sel_word.stat_day   = 22'd0;
        sel_word.last_stat  = (r_k == K_COUNT);
        unique case (r_k)
            K_START_NAV: sel_word.stat_value =
                {32'd0, (short_series ? r_begin_nav : r_start_nav)};
            K_START_TOTAL: sel_word.stat_value = {16'd0, r_start_total};
            K_END_NAV: sel_word.stat_value =
                {32'd0, (short_series ? r_begin_nav : r_item.nav_value)};
            K_END_TOTAL: sel_word.stat_value = {16'd0, r_item.total_value};
            K_MAX_RET: begin
                sel_word.stat_value = {{32{r_ret_max[31]}}, r_ret_max};
                sel_word.stat_day   = r_ret_max_day;
            end
            K_MIN_RET: begin
                sel_word.stat_value = {{32{r_ret_min[31]}}, r_ret_min};
                sel_word.stat_day   = r_ret_min_day;
            end
            K_MIN_NAV: begin
                sel_word.stat_value = {32'd0, r_nav_min};
                sel_word.stat_day   = r_nav_min_day;
            end
            K_MAX_NAV: begin
                sel_word.stat_value = {32'd0, r_nav_max};
                sel_word.stat_day   = r_nav_max_day;
            end
            K_MIN_TOTAL: begin
                sel_word.stat_value = {16'd0, r_tot_min};
                sel_word.stat_day   = r_tot_min_day;
            end
            K_MAX_TOTAL: begin
                sel_word.stat_value = {16'd0, r_tot_max};
                sel_word.stat_day   = r_tot_max_day;
            end
            K_STD_DEV: sel_word.stat_value = {20'd0, r_sd};
            K_COUNT:   sel_word.stat_value = 64'(r_count);
            default:   sel_word.stat_value = 64'sd0;
        endcase
        // A series without any return reports only the fallback NAV.
        if (short_series && (r_k != K_START_NAV) && (r_k != K_END_NAV)) begin
            sel_word.stat_value = 64'sd0;
            sel_word.stat_day   = 22'd0;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_seen        = r_seen;
        n_start_nav   = r_start_nav;
        n_start_total = r_start_total;
        n_prev        = r_prev;
        n_nav_min     = r_nav_min;
        n_nav_max     = r_nav_max;
        n_nav_min_day = r_nav_min_day;
        n_nav_max_day = r_nav_max_day;
        n_tot_min     = r_tot_min;
        n_tot_max     = r_tot_max;
        n_tot_min_day = r_tot_min_day;
        n_tot_max_day = r_tot_max_day;
        n_ret_min     = r_ret_min;
        n_ret_max     = r_ret_max;
        n_ret_min_day = r_ret_min_day;
        n_ret_max_day = r_ret_max_day;
        n_mean        = r_mean;
        n_m2          = r_m2;
        n_count       = r_count;
        n_ret         = r_ret;
        n_delta       = r_delta;
        n_sd          = r_sd;
        n_k           = r_k;
        n_out         = r_out;
        n_out_valid   = r_out_valid && i_out_stall;

        unit_req.start = 1'b0;
        unit_req.mode  = U_DIV;
        unit_req.steps = STEPS_RATIO;
        unit_req.x     = {r_item.nav_value, 56'd0};
        unit_req.d     = {1'b0, r_prev};

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_item  = i_in_word;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_seen) begin
                    // Baseline seeds the start values and the level extremes.
                    n_seen        = 1'b1;
                    n_start_nav   = r_item.nav_value;
                    n_start_total = r_item.total_value;
                    n_prev        = r_item.nav_value;
                    n_nav_min     = r_item.nav_value;
                    n_nav_max     = r_item.nav_value;
                    n_nav_min_day = r_item.day_number;
                    n_nav_max_day = r_item.day_number;
                    n_tot_min     = r_item.total_value;
                    n_tot_max     = r_item.total_value;
                    n_tot_min_day = r_item.day_number;
                    n_tot_max_day = r_item.day_number;
                    n_state       = r_item.final_day ? S_FIN : S_IDLE;
                end else if (r_prev == 32'd0) begin
                    n_ret   = (r_item.nav_value != 32'd0) ? RET_MAX : 32'sd0;
                    n_state = S_UPD;
                end else begin
                    unit_req.start = 1'b1;
                    unit_req.mode  = U_DIV;
                    unit_req.steps = STEPS_RATIO;
                    unit_req.x     = {r_item.nav_value, 56'd0};
                    unit_req.d     = {1'b0, r_prev};
                    n_state        = S_RATIO;
                end
            end
            S_RATIO: begin
                if (unit_rsp.done) begin
                    n_ret   = ret_from_ratio;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_item.total_value > r_tot_max) begin
                    n_tot_max     = r_item.total_value;
                    n_tot_max_day = r_item.day_number;
                end
                if (r_item.total_value < r_tot_min) begin
                    n_tot_min     = r_item.total_value;
                    n_tot_min_day = r_item.day_number;
                end
                if ((r_count == '0) || (r_ret > r_ret_max)) begin
                    n_ret_max     = r_ret;
                    n_ret_max_day = r_item.day_number;
                end
                if ((r_count == '0) || (r_ret < r_ret_min)) begin
                    n_ret_min     = r_ret;
                    n_ret_min_day = r_item.day_number;
                end
                if (r_item.nav_value > r_nav_max) begin
                    n_nav_max     = r_item.nav_value;
                    n_nav_max_day = r_item.day_number;
                end
                if (r_item.nav_value < r_nav_min) begin
                    n_nav_min     = r_item.nav_value;
                    n_nav_min_day = r_item.day_number;
                end
                n_count = count_inc;
                n_delta = delta_now;
                // Mean step: |delta| / n, the sign is put back afterwards.
                unit_req.start = 1'b1;
                unit_req.mode  = U_DIV;
                unit_req.steps = STEPS_MEAN;
                unit_req.x     = {mag33(delta_now), 55'd0};
                unit_req.d     = 33'(count_inc);
                n_state        = S_MEAN;
            end
            S_MEAN: begin
                if (unit_rsp.done) begin
                    n_mean  = mean_new;
                    n_state = S_MSTART;
                end
            end
            S_MSTART: begin
                unit_req.start = 1'b1;
                unit_req.mode  = U_MUL;
                unit_req.steps = STEPS_MUL;
                unit_req.x     = {b_mag, 55'd0};
                unit_req.d     = mag33(r_delta);
                n_state        = S_MUL;
            end
            S_MUL: begin
                if (unit_rsp.done) begin
                    n_m2    = m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0];
                    n_prev  = r_item.nav_value;
                    n_state = r_item.final_day ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                n_k = K_START_NAV;
                if (r_count > COUNT_BITS'(1)) begin
                    unit_req.start = 1'b1;
                    unit_req.mode  = U_DIV;
                    unit_req.steps = STEPS_VAR;
                    unit_req.x     = {r_m2, 24'd0};
                    unit_req.d     = 33'(r_count - 1'b1);
                    n_state        = S_VAR;
                end else begin
                    n_sd    = 44'd0;
                    n_state = S_EMIT;
                end
            end
            S_VAR: begin
                if (unit_rsp.done) begin
                    unit_req.start = 1'b1;
                    unit_req.mode  = U_SQRT;
                    unit_req.steps = STEPS_SQRT;
                    unit_req.x     = {unit_rsp.q, 24'd0};
                    unit_req.d     = 33'd0;
                    n_state        = S_SQRT;
                end
            end
            S_SQRT: begin
                if (unit_rsp.done) begin
                    n_sd    = unit_rsp.q[43:0];
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out       = sel_word;
                    n_out_valid = 1'b1;
                    n_k         = r_k + 4'd1;
                    if (r_k == K_COUNT) begin
                        // Series done: the next word is a new baseline.
                        n_seen        = 1'b0;
                        n_start_nav   = 32'd0;
                        n_start_total = 48'd0;
                        n_prev        = 32'd0;
                        n_nav_min     = 32'd0;
                        n_nav_max     = 32'd0;
                        n_nav_min_day = 22'd0;
                        n_nav_max_day = 22'd0;
                        n_tot_min     = 48'd0;
                        n_tot_max     = 48'd0;
                        n_tot_min_day = 22'd0;
                        n_tot_max_day = 22'd0;
                        n_ret_min     = 32'sd0;
                        n_ret_max     = 32'sd0;
                        n_ret_min_day = 22'd0;
                        n_ret_max_day = 22'd0;
                        n_mean        = 33'sd0;
                        n_m2          = 64'd0;
                        n_count       = '0;
                        n_state       = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_begin_nav   <= 32'h0001_0000;
            r_seen        <= 1'b0;
            r_start_nav   <= 32'd0;
            r_start_total <= 48'd0;
            r_prev        <= 32'd0;
            r_nav_min     <= 32'd0;
            r_nav_max     <= 32'd0;
            r_nav_min_day <= 22'd0;
            r_nav_max_day <= 22'd0;
            r_tot_min     <= 48'd0;
            r_tot_max     <= 48'd0;
            r_tot_min_day <= 22'd0;
            r_tot_max_day <= 22'd0;
            r_ret_min     <= 32'sd0;
            r_ret_max     <= 32'sd0;
            r_ret_min_day <= 22'd0;
            r_ret_max_day <= 22'd0;
            r_mean        <= 33'sd0;
            r_m2          <= 64'd0;
            r_count       <= '0;
            r_k           <= K_START_NAV;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            if (i_cfg_valid) begin
                r_begin_nav <= i_cfg_data;
            end
            r_seen        <= n_seen;
            r_start_nav   <= n_start_nav;
            r_start_total <= n_start_total;
            r_prev        <= n_prev;
            r_nav_min     <= n_nav_min;
            r_nav_max     <= n_nav_max;
            r_nav_min_day <= n_nav_min_day;
            r_nav_max_day <= n_nav_max_day;
            r_tot_min     <= n_tot_min;
            r_tot_max     <= n_tot_max;
            r_tot_min_day <= n_tot_min_day;
            r_tot_max_day <= n_tot_max_day;
            r_ret_min     <= n_ret_min;
            r_ret_max     <= n_ret_max;
            r_ret_min_day <= n_ret_min_day;
            r_ret_max_day <= n_ret_max_day;
            r_mean        <= n_mean;
            r_m2          <= n_m2;
            r_count       <= n_count;
            r_k           <= n_k;
            r_out_valid   <= n_out_valid;
        end
        r_item  <= n_item;
        r_ret   <= n_ret;
        r_delta <= n_delta;
        r_sd    <= n_sd;
        r_out   <= n_out;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/srs_iter_unit.sv =====
// ----------------------------------------------------------------------------
// srs_iter_unit
// Shared one-bit-per-cycle unit: restoring divide, square root, shift-add
// multiply, all through one adder.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_iter_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srs_pkg::t_unit_req i_req,
    output srs_pkg::t_unit_rsp o_rsp
);
    import srs_pkg::*;

    logic [87:0] r_x, n_x;
    logic [65:0] r_r, n_r;
    logic [63:0] r_q, n_q;
    logic [32:0] r_d, n_d;
    logic [1:0]  r_mode, n_mode;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    logic [65:0] opa;
    logic [65:0] opb;
    logic        sub;
    logic [66:0] sum;

    always_comb begin
        opa = {r_r[64:0], r_x[87]};
        opb = {33'd0, r_d};
        sub = 1'b1;
        unique case (r_mode)
            U_DIV: begin
                opa = {r_r[64:0], r_x[87]};
                opb = {33'd0, r_d};
                sub = 1'b1;
            end
            U_SQRT: begin
                opa = {r_r[63:0], r_x[87:86]};
                opb = {r_q, 2'b01};
                sub = 1'b1;
            end
            U_MUL: begin
                opa = {r_r[64:0], 1'b0};
                opb = r_x[87] ? {33'd0, r_d} : 66'd0;
                sub = 1'b0;
            end
            default: begin
                opa = r_r;
                opb = 66'd0;
                sub = 1'b0;
            end
        endcase
        sum = {1'b0, opa} + (sub ? (~{1'b0, opb} + 67'd1) : {1'b0, opb});
    end

    always_comb begin
        n_x    = r_x;
        n_r    = r_r;
        n_q    = r_q;
        n_d    = r_d;
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_x    = i_req.x;
            n_d    = i_req.d;
            n_mode = i_req.mode;
            n_cnt  = i_req.steps;
            n_r    = 66'd0;
            n_q    = 64'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            unique case (r_mode)
                U_DIV: begin
                    n_r = sum[66] ? opa : sum[65:0];
                    n_q = {r_q[62:0], ~sum[66]};
                    n_x = {r_x[86:0], 1'b0};
                end
                U_SQRT: begin
                    n_r = sum[66] ? opa : sum[65:0];
                    n_q = {r_q[62:0], ~sum[66]};
                    n_x = {r_x[85:0], 2'b00};
                end
                U_MUL: begin
                    n_r = sum[65:0];
                    n_x = {r_x[86:0], 1'b0};
                end
                default: begin
                    n_r = r_r;
                end
            endcase
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
            r_mode <= U_DIV;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
            r_mode <= n_mode;
        end
        r_x <= n_x;
        r_r <= n_r;
        r_q <= n_q;
        r_d <= n_d;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;
    assign o_rsp.acc  = r_r;

endmodule

`default_nettype wire

// ===== hw/rtl/srs_checker.sv =====
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks of series_return_statistics_core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "series_return_statistics_core_macros.svh"

module srs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input srs_pkg::t_out_word o_out_word
);
    import srs_pkg::*;

    // A stalled result word holds.
    `SRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

    // Only the count word closes a run.
    `SRS_ASSERT_NOW(a_last_is_count, i_clk, i_rst_n, o_out_valid && o_out_word.last_stat, o_out_word.stat_kind == K_COUNT)

    // While a run is still being reported no new sample goes in.
    `SRS_ASSERT_NOW(a_busy_in_run, i_clk, i_rst_n, o_out_valid && !o_out_word.last_stat, o_in_stall)

    // Words of a run come in kind order.
    `SRS_ASSERT_NEXT(a_kind_order, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out_word.last_stat, !o_out_valid || (o_out_word.stat_kind == $past(o_out_word.stat_kind) + 4'd1))

    // Only the extreme kinds carry a day.
    `SRS_ASSERT_NOW(a_day_zero, i_clk, i_rst_n, o_out_valid && (o_out_word.stat_kind == K_START_NAV || o_out_word.stat_kind == K_START_TOTAL || o_out_word.stat_kind == K_END_NAV || o_out_word.stat_kind == K_END_TOTAL || o_out_word.stat_kind == K_STD_DEV || o_out_word.stat_kind == K_COUNT), o_out_word.stat_day == 22'd0)

endmodule

bind series_return_statistics_core srs_checker u_srs_checker (.*);

`default_nettype wire
